### rtl/core/rmmc_pkg.sv
// ----------------------------------------------------------------------------
// rmmc_pkg
// Shared types and constants for the red marker mask and centroid unit.
// ----------------------------------------------------------------------------
package rmmc_pkg;

  // Frame size limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Fixed field widths
  localparam int COMP_W = 8;   // colour component
  localparam int CFG_W  = 11;  // size register
  localparam int CENT_W = 10;  // centroid field

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // Derived widths
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int PIX_W    = COL_W + ROW_W;
  localparam int CNT_W    = PIX_W + 1;
  localparam int DIV_Q_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int SUM_W    = DIV_Q_W + PIX_W;
  localparam int DIV_IX_W = $clog2(DIV_Q_W);

  // Front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic              mask;
    logic              frame_done;
    logic              marker_found;
    logic [CENT_W-1:0] centroid_x;
    logic [CENT_W-1:0] centroid_y;
  } res_t;

  typedef struct packed {
    logic             mask;
    logic             frame_done;
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
  } qword_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_e;

endpackage

### rtl/core/rmmc_front.sv
// ----------------------------------------------------------------------------
// rmmc_front
// Size registers, pixel classification, raster position and frame sums.
// ----------------------------------------------------------------------------
module rmmc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rmmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rmmc_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rmmc_pkg::pix_t                  in_data_i,
  input  rmmc_pkg::q_stat_t               q_stat_i,
  output logic                            push_o,
  output rmmc_pkg::qword_t                push_data_o
);
  import rmmc_pkg::*;

  logic [CFG_W-1:0] width_q, height_q;
  logic [COL_W-1:0] col_q, col_d, last_col;
  logic [ROW_W-1:0] row_q, row_d, last_row;
  logic [SUM_W-1:0] sx_q, sx_d, sx_n;
  logic [SUM_W-1:0] sy_q, sy_d, sy_n;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_n;
  logic [COMP_W:0]  gb_sum;
  logic             marked, row_end, frame_end, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    priority if (width_q == '0) last_col = '0;
    else if (int'(width_q) > MAX_WIDTH) last_col = COL_W'(MAX_WIDTH - 1);
    else last_col = COL_W'(width_q - 1'b1);
    priority if (height_q == '0) last_row = '0;
    else if (int'(height_q) > MAX_HEIGHT) last_row = ROW_W'(MAX_HEIGHT - 1);
    else last_row = ROW_W'(height_q - 1'b1);
  end

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign gb_sum    = {1'b0, in_data_i.green} + {1'b0, in_data_i.blue};
  assign marked    = {1'b0, in_data_i.red} > gb_sum;
  assign row_end   = col_q >= last_col;
  assign frame_end = row_end && (row_q >= last_row);

  assign sx_n  = marked ? sx_q + SUM_W'(col_q) : sx_q;
  assign sy_n  = marked ? sy_q + SUM_W'(row_q) : sy_q;
  assign cnt_n = cnt_q + CNT_W'(marked);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
      sx_d  = frame_end ? '0 : sx_n;
      sy_d  = frame_end ? '0 : sy_n;
      cnt_d = frame_end ? '0 : cnt_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      cnt_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      cnt_q <= cnt_d;
    end
  end

  assign push_o                 = accept;
  assign push_data_o.mask       = marked;
  assign push_data_o.frame_done = frame_end;
  assign push_data_o.cnt        = cnt_n;
  assign push_data_o.sum_x      = sx_n;
  assign push_data_o.sum_y      = sy_n;

endmodule

### rtl/core/rmmc_queue.sv
// ----------------------------------------------------------------------------
// rmmc_queue
// Short register queue between the classifier and the result stage.
// ----------------------------------------------------------------------------
module rmmc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rmmc_pkg::qword_t   push_data_i,
  input  logic               pop_i,
  output rmmc_pkg::qword_t   head_o,
  output rmmc_pkg::q_stat_t  stat_o
);
  import rmmc_pkg::*;

  qword_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   fill_q, fill_d;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) fill_d = fill_q + 1'b1;
    if (pop_i && !push_i) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      fill_q <= fill_d;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = fill_q == (QPTR_W+1)'(QDEPTH);
  assign stat_o.empty = fill_q == '0;

endmodule

### rtl/core/rmmc_back.sv
// ----------------------------------------------------------------------------
// rmmc_back
// Result stage: shared restoring divider for the centroid and output register.
// ----------------------------------------------------------------------------
module rmmc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmmc_pkg::q_stat_t  q_stat_i,
  input  rmmc_pkg::qword_t   head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rmmc_pkg::res_t     out_data_o
);
  import rmmc_pkg::*;

  bk_state_e             state_q, state_d;
  logic [SUM_W-1:0]      rem_q, dsh_q, sy_q, rem_n;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIV_Q_W-1:0]    quot_q, qx_q, quot_n;
  logic [DIV_IX_W-1:0]   idx_q;
  logic                  axis_q, mask_q;
  logic                  out_valid_q;
  res_t                  out_q;
  logic                  slot_free, div_start, div_last, ge;
  logic                  load, step, wr_direct, wr_div;

  assign slot_free = !out_valid_q || out_ready_i;
  assign div_start = !q_stat_i.empty && head_i.frame_done && (head_i.cnt != '0);
  assign div_last  = idx_q == DIV_IX_W'(DIV_Q_W - 1);

  // one quotient bit per cycle
  assign ge     = rem_q >= dsh_q;
  assign rem_n  = ge ? rem_q - dsh_q : rem_q;
  assign quot_n = {quot_q[DIV_Q_W-2:0], ge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (div_start) state_d = BK_DIV;
      BK_DIV:  if (div_last && axis_q) state_d = BK_DONE;
      BK_DONE: if (slot_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    load      = 1'b0;
    step      = 1'b0;
    wr_direct = 1'b0;
    wr_div    = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (div_start) load = 1'b1;
        else if (!q_stat_i.empty && slot_free) wr_direct = 1'b1;
      end
      BK_DIV:  step = 1'b1;
      BK_DONE: wr_div = slot_free;
      default: ;
    endcase
  end

  assign pop_o = load || wr_direct;

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q  <= head_i.sum_x;
      dsh_q  <= SUM_W'(head_i.cnt) << (DIV_Q_W - 1);
      sy_q   <= head_i.sum_y;
      cnt_q  <= head_i.cnt;
      mask_q <= head_i.mask;
      idx_q  <= '0;
      axis_q <= 1'b0;
    end else if (step) begin
      quot_q <= quot_n;
      if (div_last && !axis_q) begin
        // x done, restart on y
        qx_q   <= quot_n;
        rem_q  <= sy_q;
        dsh_q  <= SUM_W'(cnt_q) << (DIV_Q_W - 1);
        idx_q  <= '0;
        axis_q <= 1'b1;
      end else begin
        rem_q <= rem_n;
        dsh_q <= dsh_q >> 1;
        idx_q <= idx_q + 1'b1;
      end
    end
    if (wr_direct) begin
      out_q.mask         <= head_i.mask;
      out_q.frame_done   <= head_i.frame_done;
      out_q.marker_found <= 1'b0;
      out_q.centroid_x   <= '0;
      out_q.centroid_y   <= '0;
    end else if (wr_div) begin
      out_q.mask         <= mask_q;
      out_q.frame_done   <= 1'b1;
      out_q.marker_found <= 1'b1;
      out_q.centroid_x   <= CENT_W'(qx_q);
      out_q.centroid_y   <= CENT_W'(quot_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_direct || wr_div) out_valid_q <= 1'b1;
      else if (out_ready_i)    out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/red_marker_mask_centroid_unit.sv
// ----------------------------------------------------------------------------
// red_marker_mask_centroid_unit
// Red marker threshold per pixel and blob centroid per frame.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on in_*: a word is taken when in_valid_i and
// in_ready_o are both high. Every pixel gives exactly one result word on
// out_*, in order, carrying its mask bit; the word for the last pixel of a
// frame also carries frame_done, marker_found and the truncated centroid.
// Frame size is set through cfg_we_i / cfg_idx_i / cfg_data_i (index 0 width,
// index 1 height); the user must write it only while the unit is idle, and the
// unit does not enforce this. There is no read-back. An ordinary pixel passes
// through the queue and the output register. A frame-end pixel with marked
// pixels is loaded into the shared restoring divider, which works x then y,
// one quotient bit per cycle, and then hands off to the output register.
// Throughput: one pixel per cycle, set by the front classifier, while the queue
// has room; at a frame end with marked pixels the divider holds the result
// stage and the 4-word queue lets the front keep taking pixels until it fills.
// A stalled receiver holds the output register; the queue fills behind it
// and in_ready_o falls when it is full.
// Reset (rst_ni, async low) clears counters, sums, queue and output valid,
// and restores the default 640x480 frame size.
// ----------------------------------------------------------------------------
module red_marker_mask_centroid_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rmmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rmmc_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rmmc_pkg::pix_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rmmc_pkg::res_t                  out_data_o
);
  import rmmc_pkg::*;

  q_stat_t q_stat;
  qword_t  push_data, head;
  logic    push, pop;

  // classifier, position counters and frame sums
  rmmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decouples pixel intake from the divider
  rmmc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  // centroid division and output register
  rmmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty) else $error("pop from empty queue");

  a_accept_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> push) else $error("accepted pixel not queued");

  a_found_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.marker_found) |-> out_data_o.frame_done)
    else $error("marker_found outside frame end");
`endif

endmodule
